FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the PID step block.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge while out of reset.
`define PPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PPS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/pps_pkg.sv
// Package of the positional PID step: widths, register map and gain type.
// No dependencies.
`default_nettype none

package pps_pkg;

    localparam int DEFAULT_SAMPLE_BITS = 12;
    localparam int GAIN_W   = 16;
    localparam int SUM_W    = 32;
    localparam int DRIVE_W  = 51;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 4;
    localparam int REG_IDX_W = 2;

    // Register indexes (byte address is 4 * index).
    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

    // Reset gains, unsigned Q8.8: 150.0, 0.5 and 0.0.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd38400;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd128;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } t_gains;

endpackage

`default_nettype wire

FILE: rtl/pps_if.sv
// Stream interfaces of the PID step: sample beats in, drive beats out.
// Depends on pps_pkg.
`default_nettype none

interface pps_sample_if #(
    parameter int SAMPLE_BITS = pps_pkg::DEFAULT_SAMPLE_BITS
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] setpoint;
    logic [SAMPLE_BITS-1:0] measured;
    logic                   integral_enable;

    modport source (output valid, output setpoint, output measured,
                    output integral_enable, input ready);
    modport sink   (input valid, input setpoint, input measured,
                    input integral_enable, output ready);
endinterface

interface pps_drive_if;
    logic                                valid;
    logic                                ready;
    logic signed [pps_pkg::DRIVE_W-1:0]  drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

FILE: rtl/pps_apb_regs.sv
// APB gain registers of the PID step: three unsigned Q8.8 gains.
// Depends on pps_pkg.
`default_nettype none

module pps_apb_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pps_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [pps_pkg::PDATA_W-1:0]    pwdata,
    output logic      [pps_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready,
    output pps_pkg::t_gains                     o_gains
);

    pps_pkg::t_gains                      r_gains;
    logic                                 w_wr;
    logic [pps_pkg::REG_IDX_W-1:0]        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[pps_pkg::REG_IDX_W+1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop  <= pps_pkg::PROP_GAIN_RST;
            r_gains.integ <= pps_pkg::INTEG_GAIN_RST;
            r_gains.deriv <= pps_pkg::DERIV_GAIN_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                pps_pkg::REG_PROP_GAIN:  r_gains.prop  <= pwdata[pps_pkg::GAIN_W-1:0];
                pps_pkg::REG_INTEG_GAIN: r_gains.integ <= pwdata[pps_pkg::GAIN_W-1:0];
                pps_pkg::REG_DERIV_GAIN: r_gains.deriv <= pwdata[pps_pkg::GAIN_W-1:0];
                default: ; // unmapped: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            pps_pkg::REG_PROP_GAIN:  prdata = pps_pkg::PDATA_W'(r_gains.prop);
            pps_pkg::REG_INTEG_GAIN: prdata = pps_pkg::PDATA_W'(r_gains.integ);
            pps_pkg::REG_DERIV_GAIN: prdata = pps_pkg::PDATA_W'(r_gains.deriv);
            default:                 prdata = '0;
        endcase
    end

    assign o_gains = r_gains;

endmodule

`default_nettype wire

FILE: rtl/positional_pid_step.sv
// Top level of the positional PID step: four-stage pipeline plus APB gains.
// Depends on pps_pkg, pps_if, pps_apb_regs and assert_macros.svh.
`default_nettype none

// Channel   | dir | beat carries                                  | handshake
// ----------+-----+-----------------------------------------------+-------------------
// i_sample  | in  | setpoint, measured, integral_enable           | valid / ready
// o_drive   | out | drive (signed, 8 fractional bits, saturated)  | valid / ready
// APB       | in  | prop_gain @0x0, integ_gain @0x4, deriv_gain @0x8 | psel/penable, pready=1
//
// One sample beat per cycle sustained while o_drive.ready holds; each beat passes the input,
// error, product and drive registers in turn before it is shown on o_drive.
// Synchronous active-low reset clears all stage valids, the integral and the last error,
// and loads the default gains.
// Stages advance independently: a stalled drive beat holds only the stages behind it
// that are full, so i_sample.ready falls only once all four registers hold beats.

module positional_pid_step #(
    parameter int SAMPLE_BITS = pps_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    pps_sample_if.sink                        i_sample,
    pps_drive_if.source                       o_drive,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pps_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pps_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pps_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    `include "assert_macros.svh"

    localparam int ERR_W  = SAMPLE_BITS + 1;            // setpoint - measured
    localparam int DIFF_W = SAMPLE_BITS + 2;            // error - last error
    localparam int GS_W   = pps_pkg::GAIN_W + 1;        // gain with a zero sign bit
    localparam int PP_W   = GS_W + ERR_W;
    localparam int PI_W   = GS_W + pps_pkg::SUM_W;
    localparam int PD_W   = GS_W + DIFF_W;
    localparam int ACC_W  = pps_pkg::DRIVE_W + 1;       // one guard bit for the clamp

    pps_pkg::t_gains w_gains;

    // Stage handshake
    logic w_take_a, w_take_b, w_take_c, w_take_d;
    logic w_adv_a;

    // Stage A: input register
    logic                   r_vld_a;
    logic [SAMPLE_BITS-1:0] r_sp_a, r_mv_a;
    logic                   r_en_a;

    // Controller state
    logic signed [pps_pkg::SUM_W-1:0] r_error_sum;
    logic signed [ERR_W-1:0]          r_prev_err;

    // Stage B: error, integral and difference
    logic                             r_vld_b;
    logic signed [ERR_W-1:0]          r_err_b;
    logic signed [pps_pkg::SUM_W-1:0] r_sum_b;
    logic signed [DIFF_W-1:0]         r_diff_b;
    logic                             r_en_b;

    // Stage C: gain products
    logic                    r_vld_c;
    logic signed [PP_W-1:0]  r_prod_p;
    logic signed [PI_W-1:0]  r_prod_i;
    logic signed [PD_W-1:0]  r_prod_d;

    // Stage D: output register
    logic                                r_vld_d;
    logic signed [pps_pkg::DRIVE_W-1:0]  r_drive;

    logic signed [ERR_W-1:0]            w_err;
    logic signed [pps_pkg::SUM_W:0]     w_sum_wide;
    logic signed [pps_pkg::SUM_W-1:0]   w_sum;
    logic signed [DIFF_W-1:0]           w_diff;
    logic signed [PP_W-1:0]             w_prod_p;
    logic signed [PI_W-1:0]             w_prod_i;
    logic signed [PD_W-1:0]             w_prod_d;
    logic signed [ACC_W-1:0]            w_acc;
    logic signed [pps_pkg::DRIVE_W-1:0] w_drive;

    logic                               w_any_vld;
    logic                               w_all_vld;
    logic [pps_pkg::SUM_W+ERR_W-1:0]    w_state;

    pps_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (w_gains)
    );

    // A stage takes a beat when empty or when the stage ahead takes its own.
    assign w_take_d = !r_vld_d || o_drive.ready;
    assign w_take_c = !r_vld_c || w_take_d;
    assign w_take_b = !r_vld_b || w_take_c;
    assign w_take_a = !r_vld_a || w_take_b;
    assign w_adv_a  = r_vld_a && w_take_b;
    assign i_sample.ready = w_take_a;

    // Error, saturating integral and difference against the last error.
    assign w_err = $signed({1'b0, r_sp_a}) - $signed({1'b0, r_mv_a});
    assign w_sum_wide = (pps_pkg::SUM_W + 1)'(r_error_sum) + (pps_pkg::SUM_W + 1)'(w_err);
    always_comb begin
        if (w_sum_wide[pps_pkg::SUM_W] != w_sum_wide[pps_pkg::SUM_W-1]) begin
            // overflow: pin to the extreme on the side of the true sign
            w_sum = {w_sum_wide[pps_pkg::SUM_W], {(pps_pkg::SUM_W-1){~w_sum_wide[pps_pkg::SUM_W]}}};
        end else begin
            w_sum = w_sum_wide[pps_pkg::SUM_W-1:0];
        end
    end
    assign w_diff = DIFF_W'(w_err) - DIFF_W'(r_prev_err);

    // Gains are unsigned; a zero sign bit makes the products signed.
    assign w_prod_p = $signed({1'b0, w_gains.prop})  * r_err_b;
    assign w_prod_i = $signed({1'b0, w_gains.integ}) * r_sum_b;
    assign w_prod_d = $signed({1'b0, w_gains.deriv}) * r_diff_b;

    // Sum the terms and clamp to the drive range.
    assign w_acc = ACC_W'(r_prod_p) + ACC_W'(r_prod_i) + ACC_W'(r_prod_d);
    always_comb begin
        if (w_acc[ACC_W-1] != w_acc[ACC_W-2]) begin
            w_drive = {w_acc[ACC_W-1], {(pps_pkg::DRIVE_W-1){~w_acc[ACC_W-1]}}};
        end else begin
            w_drive = w_acc[pps_pkg::DRIVE_W-1:0];
        end
    end

    // Valids and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a     <= 1'b0;
            r_vld_b     <= 1'b0;
            r_vld_c     <= 1'b0;
            r_vld_d     <= 1'b0;
            r_error_sum <= '0;
            r_prev_err  <= '0;
        end else begin
            if (w_take_a) begin
                r_vld_a <= i_sample.valid;
            end
            if (w_take_b) begin
                r_vld_b <= r_vld_a;
            end
            if (w_take_c) begin
                r_vld_c <= r_vld_b;
            end
            if (w_take_d) begin
                r_vld_d <= r_vld_c;
            end
            // Commit the state as the beat leaves stage A, so the next beat sees it.
            if (w_adv_a) begin
                r_error_sum <= w_sum;
                r_prev_err  <= w_err;
            end
        end
    end

    // Payload registers: load only when a beat moves in.
    always_ff @(posedge i_clk) begin
        if (w_take_a && i_sample.valid) begin
            r_sp_a <= i_sample.setpoint;
            r_mv_a <= i_sample.measured;
            r_en_a <= i_sample.integral_enable;
        end
        if (w_adv_a) begin
            r_err_b  <= w_err;
            r_sum_b  <= w_sum;
            r_diff_b <= w_diff;
            r_en_b   <= r_en_a;
        end
        if (w_take_c && r_vld_b) begin
            r_prod_p <= w_prod_p;
            // gate the integral term but keep integrating
            r_prod_i <= r_en_b ? w_prod_i : '0;
            r_prod_d <= w_prod_d;
        end
        if (w_take_d && r_vld_c) begin
            r_drive <= w_drive;
        end
    end

    assign o_drive.valid = r_vld_d;
    assign o_drive.drive = r_drive;

    assign w_any_vld = r_vld_a || r_vld_b || r_vld_c || r_vld_d;
    assign w_all_vld = r_vld_a && r_vld_b && r_vld_c && r_vld_d;
    assign w_state   = {r_error_sum, r_prev_err};

    // Reset empties the pipeline by the next edge.
    `PPS_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !w_any_vld, "pipeline not empty after reset")
    // Integral and last error move only with a beat leaving stage A.
    `PPS_ASSERT_ALWAYS(a_state_hold, i_rst_n && !w_adv_a |=> $stable(w_state), "stray state update")
    // A beat in stage C that may move lands in the output register.
    `PPS_ASSERT(a_c_to_d, r_vld_c && w_take_d |=> r_vld_d, "beat lost before the drive stage")
    // Input is refused only when every stage holds a beat.
    `PPS_ASSERT(a_ready_full, !i_sample.ready |-> w_all_vld, "input refused with a free stage")

endmodule

`default_nettype wire
